// File: hdl/aso_pkg.sv
// ============================================================================
// aso_pkg
// Shared types, constants and constant tables of the additive sawtooth
// oscillator: quarter-wave sine table and per-harmonic reciprocals.
// ============================================================================
package aso_pkg;

    localparam int MAX_HARMONICS   = 6;
    localparam int SINE_TABLE_BITS = 10;

    // field widths
    localparam int TIME_W   = 32;
    localparam int FREQ_W   = 24;
    localparam int PHASE_W  = 16;
    localparam int OUT_W    = 18;
    localparam int CNT_W    = 3;
    localparam int DC_W     = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int ANG_W    = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HARM_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DC_OFFSET  = 1'd1;

    localparam int QUARTER_SHIFT = SINE_TABLE_BITS - 2;
    localparam int QUARTER       = 1 << QUARTER_SHIFT;
    localparam int MAG_W         = 16;

    // harmonic number travels down the chain, one past the last cell
    localparam int HNUM_W  = $clog2(MAX_HARMONICS + 2);
    localparam int HNUM_N  = 1 << HNUM_W;

    // sum: dc offset plus up to MAX_HARMONICS terms of at most 2^15
    localparam int SUM_W   = 16 + $clog2(MAX_HARMONICS + 1);

    // rounded divide by i: ((2*mag + i) * RECIP[i]) >> RECIP_SHIFT
    localparam int NUM_W       = 17;
    localparam int RECIP_SHIFT = NUM_W + $clog2(2 * MAX_HARMONICS) + 1;
    localparam int RECIP_W     = RECIP_SHIFT;
    localparam int PROD_W      = NUM_W + RECIP_W;

    typedef logic [QUARTER-1:0][MAG_W-1:0]  t_qtab;
    typedef logic [HNUM_N-1:0][RECIP_W-1:0] t_recip_tab;

    typedef struct packed {
        logic [ANG_W-1:0]         angle;
        logic [ANG_W-1:0]         base;
        logic signed [SUM_W-1:0]  sum;
        logic [HNUM_W-1:0]        hnum;
    } t_cell_data;

    // first-quadrant sine, degree-11 Taylor series in Q30, rounded to Q15
    function automatic logic [MAG_W-1:0] quarter_sine(input logic [31:0] r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] q;
        x  = ({32'd0, r} * 64'd1686629713) >> QUARTER_SHIFT;
        x2 = (x * x) >> 30;
        t  = 64'd1073741824 - x2 / 64'd110;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd72;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd42;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd20;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        q  = (s + 64'd16384) >> 15;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return q[MAG_W-1:0];
    endfunction

    function automatic t_qtab build_qtab();
        t_qtab tab;
        for (int k = 0; k < QUARTER; k++) begin
            tab[k] = quarter_sine(32'(k));
        end
        return tab;
    endfunction

    // ceil(2^RECIP_SHIFT / 2i), long division at elaboration
    function automatic t_recip_tab build_recip();
        t_recip_tab tab;
        logic [63:0] d;
        logic [63:0] n;
        logic [63:0] rem;
        logic [63:0] quo;
        for (int i = 0; i < HNUM_N; i++) begin
            if (i == 0 || i > MAX_HARMONICS) begin
                tab[i] = '0;
            end else begin
                d   = 64'(2 * i);
                n   = (64'd1 << RECIP_SHIFT) + d - 64'd1;
                rem = '0;
                quo = '0;
                for (int b = 63; b >= 0; b--) begin
                    rem = {rem[62:0], n[b]};
                    quo = {quo[62:0], 1'b0};
                    if (rem >= d) begin
                        rem    = rem - d;
                        quo[0] = 1'b1;
                    end
                end
                tab[i] = quo[RECIP_W-1:0];
            end
        end
        return tab;
    endfunction

    localparam t_qtab          QTAB       = build_qtab();
    localparam logic [MAG_W-1:0] SINE_PEAK = quarter_sine(32'(QUARTER));
    localparam t_recip_tab     RECIP      = build_recip();

endpackage

// File: hdl/additive_sawtooth_oscillator.sv
// ============================================================================
// additive_sawtooth_oscillator
// Band-limited sawtooth from a sum of sine harmonics, one sample per transfer.
// ============================================================================
// One sample per clock while the output is not stalled: a new transfer is
// taken every cycle unless i_ready holds the chain. An input transfer loads
// the phase-multiply register, then passes through one cell per harmonic
// and the saturating output register before the sample can leave.
// Harmonic i is handled by cell i, which looks up the quarter-wave sine
// table, divides by i with a reciprocal multiply and, if i is within the
// harmonic count, adds the signed term to the running sum. Every
// stage has its own valid bit and ready, so bubbles close up and inputs keep
// flowing while a finished sample waits at the output. Base phase is the low
// 32 bits of time*freq (Q0.32 turns); the phase input adds phase/2 turns.
// harmonic_count (index 0) is clamped to 1..MAX_HARMONICS; dc_offset
// (index 1, Q1.15) seeds the sum; result is saturated to signed 18 bits.
// Write the registers only while no transfer is in flight.
// ============================================================================
module additive_sawtooth_oscillator
    import aso_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]            i_cfg_data,
    // input channel
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [TIME_W-1:0]           i_time_val,
    input  logic [FREQ_W-1:0]           i_freq_val,
    input  logic signed [PHASE_W-1:0]   i_phase_val,
    // output channel
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [OUT_W-1:0]     o_sample_out
);

    localparam int PHASE_PROD_W = TIME_W + FREQ_W;
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (OUT_W-1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(1 << (OUT_W-1));

    // configuration registers
    logic [CNT_W-1:0]           r_harm_count;
    logic signed [DC_W-1:0]     r_dc_offset;
    logic [HNUM_W-1:0]          cnt_eff;

    // phase stage
    logic                       r_valid0;
    logic [ANG_W-1:0]           r_base;
    logic [ANG_W-1:0]           r_offs;
    logic [PHASE_PROD_W-1:0]    phase_prod;
    logic                       ready0;

    // cell chain
    logic                       c_valid [MAX_HARMONICS+1];
    logic                       c_ready [MAX_HARMONICS+1];
    t_cell_data                 c_data  [MAX_HARMONICS+1];

    // output stage
    logic                       r_out_valid;
    logic signed [OUT_W-1:0]    r_sample;
    logic signed [OUT_W-1:0]    n_sample;
    logic                       out_ready;
    logic signed [SUM_W-1:0]    final_sum;

    // ------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_harm_count <= CNT_W'(6);
            r_dc_offset  <= DC_W'(16384);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HARM_COUNT: r_harm_count <= i_cfg_data[CNT_W-1:0];
                CFG_DC_OFFSET:  r_dc_offset  <= i_cfg_data[DC_W-1:0];
                default: ;
            endcase
        end
    end

    // zero counts as one, anything above the chain length as the full chain
    always_comb begin
        if (r_harm_count == '0) begin
            cnt_eff = HNUM_W'(1);
        end else if (32'(r_harm_count) > MAX_HARMONICS) begin
            cnt_eff = HNUM_W'(MAX_HARMONICS);
        end else begin
            cnt_eff = HNUM_W'(r_harm_count);
        end
    end

    // ------------------------------------------------------------------
    // phase stage: base = frac(time * freq) in Q0.32 turns
    // ------------------------------------------------------------------
    assign phase_prod = PHASE_PROD_W'(i_time_val) * PHASE_PROD_W'(i_freq_val);
    assign ready0     = !r_valid0 || c_ready[0];
    assign o_ready    = ready0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
        end else if (ready0) begin
            r_valid0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready0 && i_valid) begin
            r_base <= phase_prod[ANG_W-1:0];
            r_offs <= {i_phase_val, {(ANG_W-PHASE_W){1'b0}}};
        end
    end

    // first cell sees harmonic 1 at base + offset, sum seeded with dc offset
    always_comb begin
        c_valid[0]      = r_valid0;
        c_data[0].angle = r_base + r_offs;
        c_data[0].base  = r_base;
        c_data[0].sum   = SUM_W'(r_dc_offset);
        c_data[0].hnum  = HNUM_W'(1);
    end

    // ------------------------------------------------------------------
    // one cell per harmonic
    // ------------------------------------------------------------------
    for (genvar g = 0; g < MAX_HARMONICS; g++) begin : g_cell
        aso_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[g]),
            .o_ready (c_ready[g]),
            .i_data  (c_data[g]),
            .i_cnt   (cnt_eff),
            .o_valid (c_valid[g+1]),
            .i_ready (c_ready[g+1]),
            .o_data  (c_data[g+1])
        );
    end

    // ------------------------------------------------------------------
    // output register with saturation
    // ------------------------------------------------------------------
    assign out_ready                = !r_out_valid || i_ready;
    assign c_ready[MAX_HARMONICS]   = out_ready;
    assign final_sum                = c_data[MAX_HARMONICS].sum;

    always_comb begin
        if (final_sum > SAT_HI) begin
            n_sample = SAT_HI[OUT_W-1:0];
        end else if (final_sum < SAT_LO) begin
            n_sample = SAT_LO[OUT_W-1:0];
        end else begin
            n_sample = final_sum[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= c_valid[MAX_HARMONICS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && c_valid[MAX_HARMONICS]) begin
            r_sample <= n_sample;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_sample_out = r_sample;

endmodule

// File: hdl/aso_cell.sv
// ============================================================================
// aso_cell
// One harmonic: sine lookup of its angle, rounded divide by the harmonic
// number, signed add to the sum if hnum <= i_cnt; passes angle+base on.
// ============================================================================
module aso_cell
    import aso_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_cell_data          i_data,
    input  logic [HNUM_W-1:0]   i_cnt,
    output logic                o_valid,
    input  logic                i_ready,
    output t_cell_data          o_data
);

    logic                          r_valid;
    t_cell_data                    r_data;
    t_cell_data                    n_data;

    logic [SINE_TABLE_BITS-1:0]    idx;
    logic [1:0]                    quad;
    logic [QUARTER_SHIFT:0]        r;
    logic [MAG_W-1:0]              mag;
    logic [NUM_W-1:0]              num;
    logic [PROD_W-1:0]             prod;
    logic signed [SUM_W-1:0]       term;
    logic                          neg;
    logic                          active;

    always_comb begin
        idx  = i_data.angle[ANG_W-1 -: SINE_TABLE_BITS];
        quad = idx[SINE_TABLE_BITS-1 -: 2];
        if (quad[0]) begin
            r = (QUARTER_SHIFT+1)'(QUARTER) - {1'b0, idx[QUARTER_SHIFT-1:0]};
        end else begin
            r = {1'b0, idx[QUARTER_SHIFT-1:0]};
        end
        mag = r[QUARTER_SHIFT] ? SINE_PEAK : QTAB[r[QUARTER_SHIFT-1:0]];

        // round(mag / i), ties away from zero
        num  = {mag[MAG_W-2:0], 1'b0} + NUM_W'(i_data.hnum);
        prod = PROD_W'(num) * PROD_W'(RECIP[i_data.hnum]);
        term = SUM_W'(prod[RECIP_SHIFT +: MAG_W]);

        // lower half of the wave negates; even harmonics are subtracted
        neg    = quad[1] ^ ~i_data.hnum[0];
        active = (i_data.hnum <= i_cnt);

        n_data       = i_data;
        n_data.angle = i_data.angle + i_data.base;
        n_data.hnum  = i_data.hnum + HNUM_W'(1);
        if (active) begin
            n_data.sum = neg ? (i_data.sum - term) : (i_data.sum + term);
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule
